// ===== src/midi_input_fifo_with_mtc_decode_assert.svh =====
// Assertion macros shared by the ring and top-level RTL files of the MIDI input block.
`ifndef MIDI_INPUT_FIFO_WITH_MTC_DECODE_ASSERT_SVH
`define MIDI_INPUT_FIFO_WITH_MTC_DECODE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MIMTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mimtc assertion failed");

// Next-cycle implication, checked outside reset.
`define MIMTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mimtc assertion failed");

`endif

// ===== src/mimtc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mimtc_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = PTR_W + 1;
   localparam int SIZE_W     = 11;
   localparam int WORD_W     = 32;

   localparam logic [7:0] MTC_STATUS = 8'hF1;

   typedef enum logic [1:0] {
      KIND_SHORT = 2'd0,
      KIND_LONG  = 2'd1,
      KIND_POP   = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // request from the sequencer to the ring
   typedef struct packed {
      logic       put;
      logic       pop;
      logic [7:0] data;
   } ring_cmd_type;

   // ring status back to the sequencer
   typedef struct packed {
      logic       full;
      logic       nonempty;
      logic [7:0] rd_data;
   } ring_stat_type;

   // assembled time from the quarter-frame unit
   typedef struct packed {
      logic       time_valid;
      logic [4:0] hours;
      logic [7:0] minutes;
      logic [7:0] seconds;
      logic [7:0] frames;
      logic [1:0] frame_rate;
   } qf_out_type;

   // one result beat
   typedef struct packed {
      logic [7:0] read_byte;
      logic       read_valid;
      logic       overrun;
      logic       long_done;
      logic       mtc_seen;
      qf_out_type qf;
   } res_type;

endpackage
`default_nettype wire

// ===== src/mimtc_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "midi_input_fifo_with_mtc_decode_assert.svh"
module mimtc_ring (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [mimtc_pkg::CNT_W-1:0]   used_size,
   input  mimtc_pkg::ring_cmd_type      cmd,
   output mimtc_pkg::ring_stat_type     stat
);
   import mimtc_pkg::*;

   logic [7:0]       mem [RING_DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [7:0]       rd_data_ff;
   logic [CNT_W-1:0] wp_inc, rp_inc;
   logic [PTR_W-1:0] wp_next, rp_next;

   // advance positions with wrap at the size in use
   always_comb begin
      wp_inc  = {1'b0, wp_ff} + CNT_W'(1);
      rp_inc  = {1'b0, rp_ff} + CNT_W'(1);
      wp_next = (wp_inc >= used_size) ? '0 : wp_inc[PTR_W-1:0];
      rp_next = (rp_inc >= used_size) ? '0 : rp_inc[PTR_W-1:0];
      stat.full     = (wp_next == rp_ff);
      stat.nonempty = (wp_ff != rp_ff);
      stat.rd_data  = rd_data_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (cmd.put && !stat.full) begin
         wp_in = wp_next;
      end
      if (cmd.pop && stat.nonempty) begin
         rp_in = rp_next;
      end
   end

   // hold positions
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   // write one byte per cycle while the ring is not full
   always_ff @(posedge clock) begin
      if (cmd.put && !stat.full) begin
         mem[wp_next] <= cmd.data;
      end
   end

   // registered read of the slot after the read position
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_data_ff <= mem[rp_next];
      end
   end

   `MIMTC_ASSERT_NOW(a_put_pop_excl, clock, reset, cmd.put, !cmd.pop)
   `MIMTC_ASSERT_NOW(a_pop_nonempty, clock, reset, cmd.pop, stat.nonempty)
   `MIMTC_ASSERT_NEXT(a_full_holds_wp, clock, reset, cmd.put && stat.full, $stable(wp_ff))

endmodule
`default_nettype wire

// ===== src/mimtc_qframe.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mimtc_qframe (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   strobe,
   input  wire [7:0]             data,
   output mimtc_pkg::qf_out_type qf
);
   import mimtc_pkg::*;

   logic [3:0] piece_ff [8];
   logic [2:0] exp_ff, exp_in;
   logic       match;
   logic       last_piece;

   // compare the piece number against the expected index
   always_comb begin
      match      = (data[7:4] == {1'b0, exp_ff});
      last_piece = match && (exp_ff == 3'd7);
      exp_in     = exp_ff;
      if (strobe) begin
         if (!match || exp_ff == 3'd7) begin
            exp_in = '0;
         end else begin
            exp_in = exp_ff + 3'd1;
         end
      end
      qf = '0;
      if (strobe && last_piece) begin
         qf.time_valid = 1'b1;
         qf.hours      = {data[0], piece_ff[6]};
         qf.minutes    = {piece_ff[5], piece_ff[4]};
         qf.seconds    = {piece_ff[3], piece_ff[2]};
         qf.frames     = {piece_ff[1], piece_ff[0]};
         qf.frame_rate = data[2:1];
      end
   end

   // store an in-order piece
   always_ff @(posedge clock) begin
      if (strobe && match) begin
         piece_ff[exp_ff] <= data[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= '0;
      end else begin
         exp_ff <= exp_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/midi_input_fifo_with_mtc_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "midi_input_fifo_with_mtc_decode_assert.svh"
// Channel   Direction  Handshake              Content
// req_      in         req_valid/req_ready    kind, message_word, long_byte, long_last
// rsp_      out        rsp_valid/rsp_ready    pop byte, flags, assembled time code
// csr_      in         csr_wr_en              ring_size, no wait
//
// One item at a time: a beat is taken in idle, worked, then moved to the output register.
// Short message: S_SHORT, one ring write per cycle, stopping at the first full slot;
// long byte: S_LONG; quarter frame: S_QF; pop: S_POP, S_POPWAIT (RAM read) if nonempty.
// A result waiting in the output register does not block the next beat; that beat
// holds in its last state until the output register frees.
// Synchronous reset empties the ring and restarts the time code index; ring_size is 1024.
module midi_input_fifo_with_mtc_decode (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [1:0]                    req_kind,
   input  wire [mimtc_pkg::WORD_W-1:0]  req_message_word,
   input  wire [7:0]                    req_long_byte,
   input  wire                          req_long_last,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [7:0]                   rsp_read_byte,
   output logic                         rsp_read_valid,
   output logic                         rsp_overrun,
   output logic                         rsp_long_done,
   output logic                         rsp_mtc_seen,
   output logic                         rsp_time_valid,
   output logic [4:0]                   rsp_hours,
   output logic [7:0]                   rsp_minutes,
   output logic [7:0]                   rsp_seconds,
   output logic [7:0]                   rsp_frames,
   output logic [1:0]                   rsp_frame_rate,
   input  wire                          csr_wr_en,
   input  wire [mimtc_pkg::SIZE_W-1:0]  csr_wr_data
);
   import mimtc_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SHORT   = 7'b0000010,
      S_LONG    = 7'b0000100,
      S_POP     = 7'b0001000,
      S_POPWAIT = 7'b0010000,
      S_QF      = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff;
   logic [CNT_W-1:0]  used_size;
   logic [WORD_W-1:0] word_ff;
   logic [7:0]        lbyte_ff;
   logic              last_ff;
   logic              drop_ff, drop_in;
   logic [1:0]        cnt_ff, cnt_in;
   res_type           res_ff, res_in;
   res_type           rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_load;
   ring_cmd_type      ring_cmd;
   ring_stat_type     ring_stat;
   logic              qf_strobe;
   qf_out_type        qf_out;

   assign accept   = req_valid && req_ready;
   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // clamp ring size to the legal range
   always_comb begin
      if (size_ff < SIZE_W'(2)) begin
         used_size = CNT_W'(2);
      end else if (size_ff > SIZE_W'(RING_DEPTH)) begin
         used_size = CNT_W'(RING_DEPTH);
      end else begin
         used_size = CNT_W'(size_ff);
      end
   end

   // sequence one beat through the ring or the time code unit
   always_comb begin
      state_in      = state_ff;
      res_in        = res_ff;
      drop_in       = drop_ff;
      cnt_in        = cnt_ff;
      ring_cmd      = '0;
      qf_strobe     = 1'b0;
      req_ready     = (state_ff == S_IDLE);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               cnt_in = '0;
               case (kind_type'(req_kind))
                  KIND_SHORT: begin
                     state_in = (req_message_word[7:0] == MTC_STATUS) ? S_QF : S_SHORT;
                  end
                  KIND_LONG: state_in = S_LONG;
                  KIND_POP:  state_in = S_POP;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_SHORT: begin
            ring_cmd.put  = 1'b1;
            ring_cmd.data = 8'(word_ff >> {cnt_ff, 3'b000});
            cnt_in        = cnt_ff + 2'd1;
            if (ring_stat.full) begin
               res_in.overrun = 1'b1;
               state_in       = S_DONE;
            end else if (cnt_ff == 2'd3) begin
               state_in = S_DONE;
            end
         end
         S_LONG: begin
            if (!drop_ff) begin
               ring_cmd.put  = 1'b1;
               ring_cmd.data = lbyte_ff;
               if (ring_stat.full) begin
                  res_in.overrun = 1'b1;
                  drop_in        = 1'b1;
               end
            end
            if (last_ff) begin
               res_in.long_done = 1'b1;
               drop_in          = 1'b0;
            end
            state_in = S_DONE;
         end
         S_POP: begin
            if (ring_stat.nonempty) begin
               ring_cmd.pop = 1'b1;
               state_in     = S_POPWAIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_POPWAIT: begin
            res_in.read_byte  = ring_stat.rd_data;
            res_in.read_valid = 1'b1;
            state_in          = S_DONE;
         end
         S_QF: begin
            qf_strobe       = 1'b1;
            res_in.mtc_seen = 1'b1;
            res_in.qf       = qf_out;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         drop_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_W'(RING_DEPTH);
      end else begin
         state_ff     <= state_in;
         drop_ff      <= drop_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
   end

   // capture the beat and build the result
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff  <= req_message_word;
         lbyte_ff <= req_long_byte;
         last_ff  <= req_long_last;
      end
      res_ff <= res_in;
      if (out_load) begin
         rsp_ff <= res_ff;
      end
   end

   mimtc_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .used_size (used_size),
      .cmd       (ring_cmd),
      .stat      (ring_stat)
   );

   mimtc_qframe u_qframe (
      .clock  (clock),
      .reset  (reset),
      .strobe (qf_strobe),
      .data   (word_ff[15:8]),
      .qf     (qf_out)
   );

   // drive the result ports
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_ff.read_byte;
   assign rsp_read_valid = rsp_ff.read_valid;
   assign rsp_overrun    = rsp_ff.overrun;
   assign rsp_long_done  = rsp_ff.long_done;
   assign rsp_mtc_seen   = rsp_ff.mtc_seen;
   assign rsp_time_valid = rsp_ff.qf.time_valid;
   assign rsp_hours      = rsp_ff.qf.hours;
   assign rsp_minutes    = rsp_ff.qf.minutes;
   assign rsp_seconds    = rsp_ff.qf.seconds;
   assign rsp_frames     = rsp_ff.qf.frames;
   assign rsp_frame_rate = rsp_ff.qf.frame_rate;

   `MIMTC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != S_IDLE)
   `MIMTC_ASSERT_NOW(a_time_needs_mtc, clock, reset, rsp_valid && rsp_time_valid, rsp_mtc_seen)
   `MIMTC_ASSERT_NOW(a_overrun_alone, clock, reset, rsp_valid && rsp_overrun, !rsp_read_valid && !rsp_mtc_seen)
   `MIMTC_ASSERT_NOW(a_pop_no_time, clock, reset, rsp_valid && rsp_read_valid, !rsp_time_valid && !rsp_long_done)

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import mimtc_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 12;
   localparam int STALL_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int NUM_PHASES      = 8;

   // Mirror of the receiver: ring, long-buffer drop flag, time code assembler.
   class midi_rx_board;
      logic [7:0]        ring_bytes [RING_DEPTH];
      int unsigned       wr_slot;
      int unsigned       rd_slot;
      bit                long_dropping;
      logic [3:0]        piece_nibble [8];
      logic [2:0]        piece_due;
      logic [SIZE_W-1:0] ring_size;
      res_type           pending_rx [$];
      int                errors;

      function new();
         wr_slot       = 0;
         rd_slot       = 0;
         long_dropping = 1'b0;
         piece_due     = 3'd0;
         ring_size     = SIZE_W'(RING_DEPTH);
         errors        = 0;
      endfunction

      function void set_ring_size(logic [SIZE_W-1:0] value);
         ring_size = value;
      endfunction

      function bit ring_empty();
         return wr_slot == rd_slot;
      endfunction

      function logic [2:0] next_piece();
         return piece_due;
      endfunction

      function int pending();
         return pending_rx.size();
      endfunction

      // Clamp the size register to the usable range.
      function int unsigned slots_in_use();
         int unsigned s;
         s = 32'(ring_size);
         if (s < 2) s = 2;
         if (s > RING_DEPTH) s = RING_DEPTH;
         return s;
      endfunction

      // Advance the write slot; refuse when it would hit the read slot.
      function bit ring_put(logic [7:0] b);
         int unsigned nxt;
         nxt = wr_slot + 1;
         if (nxt >= slots_in_use()) nxt = 0;
         if (nxt == rd_slot) return 1'b0;
         ring_bytes[nxt[PTR_W-1:0]] = b;
         wr_slot = nxt;
         return 1'b1;
      endfunction

      // Work out the reply to one accepted request beat and queue it.
      function void note_request(kind_type k, logic [31:0] word, logic [7:0] lb, logic last);
         res_type     r;
         int unsigned nxt;
         logic [3:0]  pnum;
         r = '0;
         case (k)
            KIND_SHORT: begin
               if (word[7:0] == MTC_STATUS) begin
                  pnum = word[15:12];
                  r.mtc_seen = 1'b1;
                  if (pnum != {1'b0, piece_due}) begin
                     // out of order: restart the index, drop the piece
                     piece_due = 3'd0;
                  end else begin
                     piece_nibble[piece_due] = word[11:8];
                     if (piece_due != 3'd7) begin
                        piece_due = piece_due + 3'd1;
                     end else begin
                        piece_due           = 3'd0;
                        r.qf.time_valid     = 1'b1;
                        r.qf.hours          = {piece_nibble[7][0], piece_nibble[6]};
                        r.qf.minutes        = {piece_nibble[5], piece_nibble[4]};
                        r.qf.seconds        = {piece_nibble[3], piece_nibble[2]};
                        r.qf.frames         = {piece_nibble[1], piece_nibble[0]};
                        r.qf.frame_rate     = piece_nibble[7][2:1];
                     end
                  end
               end else begin
                  // store bytes lowest first, stop at the first full slot
                  for (int i = 0; i < 4; i++) begin
                     if (!ring_put(word[8*i +: 8])) begin
                        r.overrun = 1'b1;
                        break;
                     end
                  end
               end
            end
            KIND_LONG: begin
               if (!long_dropping && !ring_put(lb)) begin
                  r.overrun     = 1'b1;
                  long_dropping = 1'b1;
               end
               if (last) begin
                  r.long_done   = 1'b1;
                  long_dropping = 1'b0;
               end
            end
            KIND_POP: begin
               if (rd_slot != wr_slot) begin
                  nxt = rd_slot + 1;
                  if (nxt >= slots_in_use()) nxt = 0;
                  rd_slot      = nxt;
                  r.read_byte  = ring_bytes[nxt[PTR_W-1:0]];
                  r.read_valid = 1'b1;
               end
            end
            default: ;
         endcase
         pending_rx.push_back(r);
      endfunction

      function void cmp(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      // Compare one reply beat against the oldest queued reply.
      function void check_reply(res_type got);
         res_type want;
         if (pending_rx.size() == 0) begin
            $error("reply beat with nothing outstanding");
            errors++;
            return;
         end
         want = pending_rx.pop_front();
         cmp("read_byte", 32'(want.read_byte), 32'(got.read_byte));
         cmp("read_valid", 32'(want.read_valid), 32'(got.read_valid));
         cmp("overrun", 32'(want.overrun), 32'(got.overrun));
         cmp("long_done", 32'(want.long_done), 32'(got.long_done));
         cmp("mtc_seen", 32'(want.mtc_seen), 32'(got.mtc_seen));
         cmp("time_valid", 32'(want.qf.time_valid), 32'(got.qf.time_valid));
         cmp("hours", 32'(want.qf.hours), 32'(got.qf.hours));
         cmp("minutes", 32'(want.qf.minutes), 32'(got.qf.minutes));
         cmp("seconds", 32'(want.qf.seconds), 32'(got.qf.seconds));
         cmp("frames", 32'(want.qf.frames), 32'(got.qf.frames));
         cmp("frame_rate", 32'(want.qf.frame_rate), 32'(got.qf.frame_rate));
      endfunction
   endclass

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   wire               req_ready;
   logic [1:0]        req_kind         = KIND_SHORT;
   logic [WORD_W-1:0] req_message_word = '0;
   logic [7:0]        req_long_byte    = '0;
   logic              req_long_last    = 1'b0;
   wire               rsp_valid;
   logic              rsp_ready        = 1'b0;
   wire  [7:0]        rsp_read_byte;
   wire               rsp_read_valid;
   wire               rsp_overrun;
   wire               rsp_long_done;
   wire               rsp_mtc_seen;
   wire               rsp_time_valid;
   wire  [4:0]        rsp_hours;
   wire  [7:0]        rsp_minutes;
   wire  [7:0]        rsp_seconds;
   wire  [7:0]        rsp_frames;
   wire  [1:0]        rsp_frame_rate;
   logic              csr_wr_en        = 1'b0;
   logic [SIZE_W-1:0] csr_wr_data      = '0;

   midi_rx_board board;
   bit           quiet_phase = 1'b0;
   int           sent_items  = 0;
   int           stall_left  = 0;
   int           idle_cycles = 0;

   midi_input_fifo_with_mtc_decode dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_message_word (req_message_word),
      .req_long_byte    (req_long_byte),
      .req_long_last    (req_long_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_overrun      (rsp_overrun),
      .rsp_long_done    (rsp_long_done),
      .rsp_mtc_seen     (rsp_mtc_seen),
      .rsp_time_valid   (rsp_time_valid),
      .rsp_hours        (rsp_hours),
      .rsp_minutes      (rsp_minutes),
      .rsp_seconds      (rsp_seconds),
      .rsp_frames       (rsp_frames),
      .rsp_frame_rate   (rsp_frame_rate),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Mostly short idle stretches, a few long ones, none in quiet phases.
   function automatic int pick_idle();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] mtc_word(logic [3:0] pnum, logic [3:0] nib);
      logic [15:0] upper;
      upper = 16'($urandom_range(0, 65535));
      return {upper, pnum, nib, MTC_STATUS};
   endfunction

   // Take reply beats and stall the reply side at random.
   always @(posedge clock) begin : reply_side
      res_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.read_byte     = rsp_read_byte;
         seen.read_valid    = rsp_read_valid;
         seen.overrun       = rsp_overrun;
         seen.long_done     = rsp_long_done;
         seen.mtc_seen      = rsp_mtc_seen;
         seen.qf.time_valid = rsp_time_valid;
         seen.qf.hours      = rsp_hours;
         seen.qf.minutes    = rsp_minutes;
         seen.qf.seconds    = rsp_seconds;
         seen.qf.frames     = rsp_frames;
         seen.qf.frame_rate = rsp_frame_rate;
         board.check_reply(seen);
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_idle();
      end
   end

   // Count cycles with no beat on either side; give up past the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one request beat after a random gap and hold it until taken.
   task automatic send_item(kind_type k, logic [31:0] word, logic [7:0] lb, logic last);
      int gap;
      gap = pick_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= k;
      req_message_word <= word;
      req_long_byte    <= lb;
      req_long_last    <= last;
      do @(posedge clock); while (!req_ready);
      board.note_request(k, word, lb, last);
      if (k != KIND_NONE) sent_items++;
   endtask

   task automatic send_pop();
      send_item(KIND_POP, $urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_piece(logic [3:0] pnum, logic [3:0] nib);
      send_item(KIND_SHORT, mtc_word(pnum, nib), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
   endtask

   // Drop valid and wait for every outstanding reply, then let the block go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ring_size(logic [SIZE_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_ring_size(value);
   endtask

   // Empty the ring so a size change never exposes unwritten slots.
   task automatic drain_ring();
      while (!board.ring_empty()) send_pop();
   endtask

   // Extremes, every kind, a full time code, out-of-order pieces.
   task automatic run_directed_basic();
      send_pop();
      send_item(KIND_SHORT, 32'h0000_0000, 8'h00, 1'b0);
      send_item(KIND_SHORT, 32'hFFFF_FFFF, 8'hFF, 1'b1);
      send_item(KIND_NONE, $urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(KIND_LONG, $urandom, 8'h00, 1'b0);
      send_item(KIND_LONG, $urandom, 8'hFF, 1'b1);
      repeat (3) send_pop();
      for (int p = 0; p < 8; p++) send_piece(p[3:0], 4'hF);
      // piece out of order, then a repeated piece zero
      send_piece(4'd5, 4'h0);
      send_piece(4'd0, 4'h0);
      send_piece(4'd0, 4'h0);
   endtask

   // Two-slot ring: overrun on a short message and on a long buffer.
   task automatic run_directed_small_ring();
      send_item(KIND_SHORT, 32'h1234_5678, 8'h00, 1'b0);
      send_pop();
      send_item(KIND_SHORT, 32'h8765_4321, 8'h00, 1'b0);
      send_item(KIND_LONG, $urandom, 8'hA5, 1'b0);
      send_item(KIND_LONG, $urandom, 8'h5A, 1'b0);
      send_item(KIND_LONG, $urandom, 8'hC3, 1'b1);
      repeat (2) send_pop();
   endtask

   // One random burst: a time code run, a short message, a long buffer or pops.
   task automatic random_burst();
      int         pick;
      int         len;
      logic [3:0] pnum;
      logic       last;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         // resync first if the assembler is mid-run
         if (board.next_piece() != 3'd0) send_piece(4'd0, 4'($urandom_range(0, 15)));
         for (int p = 0; p < 8; p++) begin
            pnum = p[3:0];
            if ($urandom_range(0, 99) < 6) pnum = 4'($urandom_range(0, 15));
            send_piece(pnum, 4'($urandom_range(0, 15)));
            if (pnum != p[3:0] && $urandom_range(0, 1) == 1) break;
         end
      end else if (pick < 45) begin
         send_item(KIND_SHORT, $urandom, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end else if (pick < 60) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            last = (i == len - 1) && ($urandom_range(0, 9) != 0);
            send_item(KIND_LONG, $urandom, 8'($urandom_range(0, 255)), last);
         end
      end else if (pick < 97) begin
         len = $urandom_range(1, 6);
         repeat (len) send_pop();
      end else begin
         send_item(KIND_NONE, $urandom, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end
   endtask

   task automatic random_phase(int count);
      int target;
      target = sent_items + count;
      while (sent_items < target) random_burst();
   endtask

   initial begin
      logic [SIZE_W-1:0] sizes [NUM_PHASES];
      board    = new();
      sizes[0] = 11'd0;
      sizes[1] = 11'd3;
      sizes[2] = 11'd2047;
      sizes[3] = 11'd1;
      sizes[4] = 11'd1024;
      sizes[5] = 11'd7;
      sizes[6] = 11'd1500;
      sizes[7] = SIZE_W'($urandom_range(2, 40));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed_basic();
      drain_ring();
      settle();
      write_ring_size(11'd2);
      run_directed_small_ring();

      // Sweep ring sizes; every third phase runs without idling.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         quiet_phase = (ph % 3 == 2);
         drain_ring();
         settle();
         write_ring_size(sizes[ph]);
         random_phase(ITEMS_PER_PHASE);
      end

      quiet_phase = 1'b0;
      settle();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
